>>> design/byte_stream_reassembler_macros.svh
// Assertion macros for the byte stream reassembler.
// Used by the top level only; no dependencies.
`ifndef BYTE_STREAM_REASSEMBLER_MACROS_SVH
`define BYTE_STREAM_REASSEMBLER_MACROS_SVH

// same-cycle implication
`define BSR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BSR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/bsr_pkg.sv
// Types and codes shared by the byte stream reassembler modules.
// No dependencies.
`default_nettype none
package bsr_pkg;

   localparam int CNT_W = 13;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [1:0] PS_STORED = 2'd0;
   localparam logic [1:0] PS_DUP    = 2'd1;
   localparam logic [1:0] PS_BEYOND = 2'd2;
   localparam logic [1:0] PS_NONE   = 2'd3;

   typedef struct packed {
      logic        req_type;
      logic [31:0] stream_index;
      logic [7:0]  data_byte;
      logic        has_byte;
      logic        ends_stream;
   } bsr_req_type;

   typedef struct packed {
      logic [7:0]       read_byte;
      logic             read_valid;
      logic [1:0]       push_status;
      logic [31:0]      assembled_position;
      logic [CNT_W-1:0] pending_count;
      logic [CNT_W-1:0] buffered_count;
      logic             stream_finished;
   } bsr_rsp_type;

   typedef enum logic {
      OPK_PUSH,
      OPK_READ
   } bsr_opk_type;

   typedef struct packed {
      bsr_opk_type kind;
      logic [31:0] stream_index;
      logic [7:0]  data_byte;
      logic        has_byte;
      logic        ends_stream;
   } bsr_op_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_WAIT,
      S_CHECK,
      S_HELD_WAIT,
      S_ADV_RD,
      S_ADV_CHK,
      S_RESP
   } bsr_state_type;

endpackage
`default_nettype wire

>>> design/bsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/bsr_front.sv
// Front end: accepts request beats, classifies them and queues them for the back end.
// Depends on bsr_pkg.
`default_nettype none
module bsr_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output      logic                 full,
   input  wire bsr_pkg::bsr_req_type req_item,
   output      logic                 op_valid,
   input  wire logic                 op_ready,
   output      bsr_pkg::bsr_op_type  op
);

   bsr_pkg::bsr_op_type slot_ff [2];
   bsr_pkg::bsr_op_type slot_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   always_comb begin
      slot_in.kind         = (req_item.req_type == bsr_pkg::REQ_READ) ?
                             bsr_pkg::OPK_READ : bsr_pkg::OPK_PUSH;
      slot_in.stream_index = req_item.stream_index;
      slot_in.data_byte    = req_item.data_byte;
      slot_in.has_byte     = req_item.has_byte;
      slot_in.ends_stream  = req_item.ends_stream;
   end

   assign full     = (count_ff == 2'd2);
   assign op_valid = (count_ff != 2'd0);
   assign op       = slot_ff[rd_ptr_ff];
   assign do_wr    = push && !full;
   assign do_rd    = op_valid && op_ready;

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule
`default_nettype wire

>>> design/bsr_back.sv
// Back end: ring and held-bit memories, window check, store, advance and read-out.
// Depends on bsr_pkg and bsr_ram.
`default_nettype none
module bsr_back #(
   parameter int CAPACITY = 4096
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                op_valid,
   output      logic                op_ready,
   input  wire bsr_pkg::bsr_op_type op,
   output      logic                empty,
   input  wire logic                pop,
   output      bsr_pkg::bsr_rsp_type rsp_item
);

   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int NW = bsr_pkg::CNT_W;
   localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);
   localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
   localparam logic [SW:0]   CAP_SUM   = (SW+1)'(CAPACITY);

   bsr_pkg::bsr_state_type state_ff, state_in;
   bsr_pkg::bsr_op_type    op_ff, op_in;
   bsr_pkg::bsr_rsp_type   rsp_ff, rsp_in;
   logic [31:0]   next_ff, next_in;
   logic [31:0]   read_ff, read_in;
   logic [31:0]   endp_ff, endp_in;
   logic          end_seen_ff, end_seen_in;
   logic [CW-1:0] pend_ff, pend_in;
   logic [CW-1:0] buf_ff, buf_in;
   logic [SW-1:0] head_ff, head_in;
   logic [SW-1:0] nslot_ff, nslot_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic [31:0]   d_ff, d_in;
   logic [1:0]    status_ff, status_in;
   logic [7:0]    rbyte_ff, rbyte_in;
   logic          rvalid_ff, rvalid_in;
   logic          rsp_vld_ff, rsp_vld_in;

   logic [CW-1:0] room;
   logic          in_window;
   logic [SW:0]   slot_sum;
   logic [SW-1:0] slot_calc;
   logic          rsp_free;
   logic [31:0]   fin_diff;
   logic [CW+NW-1:0] pend_x, buf_x;

   logic          ring_wr_en, ring_rd_en;
   logic [SW-1:0] ring_wr_addr;
   logic [7:0]    ring_wr_data, ring_rd_data;
   logic          held_wr_en, held_rd_en;
   logic [SW-1:0] held_wr_addr, held_rd_addr;
   logic          held_wr_data, held_rd_data;

   bsr_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_en   (ring_rd_en),
      .rd_addr (head_ff),
      .rd_data (ring_rd_data)
   );

   bsr_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_held (
      .clock   (clock),
      .wr_en   (held_wr_en),
      .wr_addr (held_wr_addr),
      .wr_data (held_wr_data),
      .rd_en   (held_rd_en),
      .rd_addr (held_rd_addr),
      .rd_data (held_rd_data)
   );

   always_comb begin
      room      = CAP_CNT - buf_ff;
      in_window = !d_ff[31] && (d_ff < 32'(room));
      slot_sum  = {1'b0, nslot_ff} + {1'b0, d_ff[SW-1:0]};
      slot_calc = (slot_sum >= CAP_SUM) ? SW'(slot_sum - CAP_SUM) : slot_sum[SW-1:0];
      rsp_free  = !rsp_vld_ff || pop;
      fin_diff  = next_ff - endp_ff;
      pend_x    = {{NW{1'b0}}, pend_ff};
      buf_x     = {{NW{1'b0}}, buf_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsr_pkg::S_CLEAR: begin
            if (clr_ff == LAST_SLOT) state_in = bsr_pkg::S_IDLE;
         end
         bsr_pkg::S_IDLE: begin
            if (op_valid) begin
               if (op.kind == bsr_pkg::OPK_READ) begin
                  state_in = (next_ff != read_ff) ? bsr_pkg::S_RD_WAIT : bsr_pkg::S_RESP;
               end else begin
                  state_in = op.has_byte ? bsr_pkg::S_CHECK : bsr_pkg::S_RESP;
               end
            end
         end
         bsr_pkg::S_RD_WAIT:   state_in = bsr_pkg::S_RESP;
         bsr_pkg::S_CHECK:     state_in = in_window ? bsr_pkg::S_HELD_WAIT : bsr_pkg::S_RESP;
         bsr_pkg::S_HELD_WAIT: state_in = held_rd_data ? bsr_pkg::S_RESP : bsr_pkg::S_ADV_RD;
         bsr_pkg::S_ADV_RD:    state_in = (buf_ff == CAP_CNT) ? bsr_pkg::S_RESP
                                                               : bsr_pkg::S_ADV_CHK;
         bsr_pkg::S_ADV_CHK:   state_in = held_rd_data ? bsr_pkg::S_ADV_RD : bsr_pkg::S_RESP;
         bsr_pkg::S_RESP: begin
            if (rsp_free) state_in = bsr_pkg::S_IDLE;
         end
         default:              state_in = bsr_pkg::S_CLEAR;
      endcase
   end

   // memory controls
   always_comb begin
      op_ready     = (state_ff == bsr_pkg::S_IDLE);
      ring_rd_en   = (state_ff == bsr_pkg::S_IDLE) && op_valid && (op.kind == bsr_pkg::OPK_READ);
      ring_wr_en   = (state_ff == bsr_pkg::S_HELD_WAIT) && !held_rd_data;
      ring_wr_addr = slot_ff;
      ring_wr_data = op_ff.data_byte;
      held_rd_en   = 1'b0;
      held_rd_addr = nslot_ff;
      held_wr_en   = 1'b0;
      held_wr_addr = nslot_ff;
      held_wr_data = 1'b0;
      case (state_ff)
         bsr_pkg::S_CLEAR: begin
            held_wr_en   = 1'b1;
            held_wr_addr = clr_ff;
         end
         bsr_pkg::S_CHECK: begin
            held_rd_en   = in_window;
            held_rd_addr = slot_calc;
         end
         bsr_pkg::S_HELD_WAIT: begin
            held_wr_en   = !held_rd_data;
            held_wr_addr = slot_ff;
            held_wr_data = 1'b1;
         end
         bsr_pkg::S_ADV_RD: begin
            held_rd_en   = (buf_ff != CAP_CNT);
         end
         bsr_pkg::S_ADV_CHK: begin
            held_wr_en   = held_rd_data;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      op_in       = op_ff;
      next_in     = next_ff;
      read_in     = read_ff;
      endp_in     = endp_ff;
      end_seen_in = end_seen_ff;
      pend_in     = pend_ff;
      buf_in      = buf_ff;
      head_in     = head_ff;
      nslot_in    = nslot_ff;
      slot_in     = slot_ff;
      clr_in      = clr_ff;
      d_in        = d_ff;
      status_in   = status_ff;
      rbyte_in    = rbyte_ff;
      rvalid_in   = rvalid_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = rsp_vld_ff && !pop;
      case (state_ff)
         bsr_pkg::S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
         end
         bsr_pkg::S_IDLE: begin
            if (op_valid) begin
               op_in     = op;
               status_in = bsr_pkg::PS_NONE;
               rbyte_in  = 8'd0;
               rvalid_in = 1'b0;
               d_in      = op.stream_index - next_ff;
               if (op.kind == bsr_pkg::OPK_PUSH && op.ends_stream) begin
                  endp_in     = op.stream_index + 32'(op.has_byte);
                  end_seen_in = 1'b1;
               end
            end
         end
         bsr_pkg::S_RD_WAIT: begin
            rbyte_in  = ring_rd_data;
            rvalid_in = 1'b1;
            read_in   = read_ff + 32'd1;
            head_in   = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
            buf_in    = buf_ff - 1'b1;
         end
         bsr_pkg::S_CHECK: begin
            if (d_ff[31]) begin
               status_in = bsr_pkg::PS_DUP;
            end else if (!in_window) begin
               status_in = bsr_pkg::PS_BEYOND;
            end
            slot_in = slot_calc;
         end
         bsr_pkg::S_HELD_WAIT: begin
            if (held_rd_data) begin
               status_in = bsr_pkg::PS_DUP;
            end else begin
               status_in = bsr_pkg::PS_STORED;
               pend_in   = pend_ff + 1'b1;
            end
         end
         bsr_pkg::S_ADV_CHK: begin
            if (held_rd_data) begin
               pend_in  = pend_ff - 1'b1;
               buf_in   = buf_ff + 1'b1;
               next_in  = next_ff + 32'd1;
               nslot_in = (nslot_ff == LAST_SLOT) ? '0 : nslot_ff + 1'b1;
            end
         end
         bsr_pkg::S_RESP: begin
            if (rsp_free) begin
               rsp_vld_in                = 1'b1;
               rsp_in.read_byte          = rbyte_ff;
               rsp_in.read_valid         = rvalid_ff;
               rsp_in.push_status        = status_ff;
               rsp_in.assembled_position = next_ff;
               rsp_in.pending_count      = pend_x[NW-1:0];
               rsp_in.buffered_count     = buf_x[NW-1:0];
               rsp_in.stream_finished    = end_seen_ff && !fin_diff[31];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bsr_pkg::S_CLEAR;
         clr_ff      <= '0;
         next_ff     <= '0;
         read_ff     <= '0;
         endp_ff     <= '0;
         end_seen_ff <= 1'b0;
         pend_ff     <= '0;
         buf_ff      <= '0;
         head_ff     <= '0;
         nslot_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         next_ff     <= next_in;
         read_ff     <= read_in;
         endp_ff     <= endp_in;
         end_seen_ff <= end_seen_in;
         pend_ff     <= pend_in;
         buf_ff      <= buf_in;
         head_ff     <= head_in;
         nslot_ff    <= nslot_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      slot_ff   <= slot_in;
      d_ff      <= d_in;
      status_ff <= status_in;
      rbyte_ff  <= rbyte_in;
      rvalid_ff <= rvalid_in;
      rsp_ff    <= rsp_in;
   end

   assign empty    = !rsp_vld_ff;
   assign rsp_item = rsp_ff;

endmodule
`default_nettype wire

>>> design/byte_stream_reassembler.sv
// Top level of the byte stream reassembler: front queue plus back engine.
// Depends on bsr_pkg, bsr_front, bsr_back, bsr_ram and the assertion macro header.
//
//   channel   ports                    direction
//   request   push, full, req_item     in   (one beat: push byte, end mark or read)
//   response  empty, pop, rsp_item     out  (one beat per request, in order)
//
// Read: one ring read when a byte is ready; end mark alone: straight to the response;
// byte push: window check, then a held-bit read unless dropped, and when stored an
// advance over held bytes, each advance step being one read of the held-bit memory.
// After reset a clearing pass over every slot zeroes the held bits; no beat
// is taken by the engine until it ends. A two-beat request queue and a response
// register let either side stall on its own.
`default_nettype none
`include "byte_stream_reassembler_macros.svh"
module byte_stream_reassembler #(
   parameter int CAPACITY = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output      logic                 full,
   input  wire bsr_pkg::bsr_req_type req_item,
   output      logic                 empty,
   input  wire logic                 pop,
   output      bsr_pkg::bsr_rsp_type rsp_item
);

   logic                op_valid;
   logic                op_ready;
   bsr_pkg::bsr_op_type op;

   bsr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .op_valid (op_valid),
      .op_ready (op_ready),
      .op       (op)
   );

   bsr_back #(.CAPACITY(CAPACITY)) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_ready (op_ready),
      .op       (op),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   `BSR_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, empty, "response pending after reset")
   `BSR_ASSERT_IMP(a_read_status, clock, reset, !empty && rsp_item.read_valid, rsp_item.push_status == bsr_pkg::PS_NONE, "read beat with push status")
   `BSR_ASSERT_IMP(a_push_no_byte, clock, reset, !empty && rsp_item.push_status != bsr_pkg::PS_NONE, !rsp_item.read_valid && rsp_item.read_byte == 8'd0, "push beat returned a byte")
   `BSR_ASSERT_NXT(a_engine_busy, clock, reset, op_valid && op_ready, !op_ready, "engine took two ops back to back")

endmodule
`default_nettype wire
